[hdl/lhe_pkg.sv]
// Shared types and constants for the luma histogram equalizer.
// Used by lhe_bin_mem, lhe_divider and luma_histogram_equalizer.
// Depends on nothing.
package lhe_pkg;

    localparam int LEVELS     = 256;
    localparam int LUMA_W     = 8;
    localparam int CNT_W      = 23;               // bin counts, pixel total, running sum
    localparam int DEN_W      = CNT_W + 1;        // 2 * pixel total
    localparam int NUM_W      = 32;               // 510 * cum + total
    localparam int QUO_W      = 8;

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(4194304);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_MAP   = 2'd2;

    typedef logic [LUMA_W-1:0] luma_t;
    typedef logic [CNT_W-1:0]  count_t;

    // One write port and one read port of the bin memory.
    typedef struct packed {
        logic   we;
        luma_t  waddr;
        count_t wdata;
        luma_t  raddr;
    } bin_port_t;

endpackage

[hdl/lhe_bin_mem.sv]
// Histogram bin store: 256 x 23-bit synchronous memory, registered read.
// Depends on lhe_pkg.
module lhe_bin_mem (
    input  logic                aclk,
    input  lhe_pkg::bin_port_t  port,
    output lhe_pkg::count_t     rdata
);
    import lhe_pkg::*;

    count_t mem [LEVELS];

    always_ff @(posedge aclk) begin
        if (port.we) begin
            mem[port.waddr] <= port.wdata;
        end
        rdata <= mem[port.raddr];
    end

endmodule

[hdl/lhe_divider.sv]
// Restoring divider giving an 8-bit quotient, one quotient bit per cycle.
// The caller guarantees num < 256 * den. Depends on lhe_pkg.
module lhe_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lhe_pkg::NUM_W-1:0]   num,
    input  logic [lhe_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [lhe_pkg::QUO_W-1:0]   quotient
);
    import lhe_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits     = rem_reg >= dsh_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            dsh_reg  <= NUM_W'(den) << (QUO_W - 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(QUO_W - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg  <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

endmodule

[hdl/luma_histogram_equalizer.sv]
// Luma histogram equalizer: add, build and map items on one valid/ready channel.
// Add item: the bin is read on accept and written back in ST_ADD. Map item: the entry is
// read on accept; ST_MAP then registers it and raises valid. Build item: each bin in turn
// goes through read, accumulate, numerator, divider and write.
// Reset (aresetn low, synchronous) starts a pass that zeroes all bins and map entries;
// no item is accepted until it ends. Depends on lhe_pkg, lhe_bin_mem, lhe_divider.
module luma_histogram_equalizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_luma,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_mapped_luma
);
    import lhe_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_MAP   = 3'd3;
    localparam logic [2:0] ST_BREAD = 3'd4;
    localparam logic [2:0] ST_BACC  = 3'd5;
    localparam logic [2:0] ST_BNUM  = 3'd6;
    localparam logic [2:0] ST_BDIV  = 3'd7;

    logic [2:0]   state_reg, state_next;
    luma_t        idx_reg, idx_next;          // clear sweep and build walk position
    luma_t        addr_reg, addr_next;        // bin being incremented
    count_t       total_reg, total_next;
    count_t       cum_reg, cum_next;
    logic         m_valid_reg, m_valid_next;
    luma_t        m_data_reg;

    bin_port_t    bin_port;
    count_t       bin_rdata;

    // Level map store, lives here
    luma_t        map_mem [LEVELS];
    luma_t        map_rdata;
    logic         map_we;
    luma_t        map_waddr;
    luma_t        map_wdata;
    luma_t        map_raddr;

    logic         div_start;
    logic         div_done;
    luma_t        div_quo;
    logic [NUM_W-1:0] num_value;

    logic         accept;

    // Hold off new items while busy or while an earlier result still waits.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_mapped_luma = m_data_reg;

    // 510 * cum + total, all exact; cum <= total <= MAX_PIXELS keeps it in 32 bits.
    assign num_value = (NUM_W'(cum_reg) << 9) - (NUM_W'(cum_reg) << 1) + NUM_W'(total_reg);

    lhe_bin_mem u_bin_mem (
        .aclk  (aclk),
        .port  (bin_port),
        .rdata (bin_rdata)
    );

    lhe_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (num_value),
        .den      ({total_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata <= map_mem[map_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        total_next   = total_reg;
        cum_next     = cum_reg;
        m_valid_next = m_valid_reg;

        bin_port.we    = 1'b0;
        bin_port.waddr = idx_reg;
        bin_port.wdata = '0;
        bin_port.raddr = s_luma;

        map_we    = 1'b0;
        map_waddr = idx_reg;
        map_wdata = '0;
        map_raddr = s_luma;

        div_start = 1'b0;

        // Drop the result once taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // Zero one bin and one map entry per cycle after reset.
                bin_port.we = 1'b1;
                map_we      = 1'b1;
                idx_next    = idx_reg + LUMA_W'(1);
                if (idx_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        OP_ADD: begin
                            // Read the bin now; write it back next cycle.
                            if (total_reg < MAX_PIXELS) begin
                                total_next = total_reg + CNT_W'(1);
                                addr_next  = s_luma;
                                state_next = ST_ADD;
                            end
                        end
                        OP_BUILD: begin
                            idx_next   = '0;
                            cum_next   = '0;
                            state_next = ST_BREAD;
                        end
                        OP_MAP: begin
                            state_next = ST_MAP;
                        end
                        default: begin
                            // Unused code: ignore the item.
                        end
                    endcase
                end
            end
            ST_ADD: begin
                bin_port.we    = 1'b1;
                bin_port.waddr = addr_reg;
                bin_port.wdata = bin_rdata + CNT_W'(1);
                state_next     = ST_IDLE;
            end
            ST_MAP: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_BREAD: begin
                bin_port.raddr = idx_reg;
                state_next     = ST_BACC;
            end
            ST_BACC: begin
                // Accumulate and clear the bin in the same pass.
                cum_next    = cum_reg + bin_rdata;
                bin_port.we = 1'b1;
                state_next  = ST_BNUM;
            end
            ST_BNUM: begin
                div_start  = 1'b1;
                state_next = ST_BDIV;
            end
            ST_BDIV: begin
                if (div_done) begin
                    map_we    = 1'b1;
                    // Empty histogram maps everything to zero.
                    map_wdata = (total_reg == '0) ? '0 : div_quo;
                    idx_next  = idx_reg + LUMA_W'(1);
                    if (idx_reg == '1) begin
                        total_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_BREAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        cum_reg  <= cum_next;
        if (state_reg == ST_MAP) begin
            m_data_reg <= map_rdata;
        end
    end

endmodule

[dv/tb_luma_histogram_equalizer.sv]
// Self-checking testbench for luma_histogram_equalizer: directed table, then random
// add/build/map phases checked against an in-bench equalization predictor.
// Depends on lhe_pkg and the luma_histogram_equalizer RTL.
`timescale 1ns / 100ps

module tb_luma_histogram_equalizer;
    import lhe_pkg::*;

    // The spare operation code is not in the package; the block must ignore it.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 1600;
    localparam int STEADY_FROM     = 1450;     // random items after which nobody idles
    // Longest quiet stretch of a correct run is one build walk plus a stall burst, or the
    // clearing pass after reset; allow several times that.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int TAIL_CYCLES     = 4000;     // covers a build still walking at the end

    // One row of the directed table. has_want marks rows whose result is typed in.
    typedef struct packed {
        logic [1:0] op;
        luma_t      luma;
        logic       has_want;
        luma_t      want;
    } stim_row_t;

    localparam int N_DIRECTED = 22;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_MAP,   8'd0,   1'b1, 8'd0},    // map after reset reads zero
        '{OP_MAP,   8'd255, 1'b1, 8'd0},
        '{OP_SPARE, 8'hAA,  1'b0, 8'd0},    // spare code: ignored
        '{OP_BUILD, 8'd0,   1'b0, 8'd0},    // empty histogram: map all zero
        '{OP_MAP,   8'd128, 1'b1, 8'd0},
        '{OP_ADD,   8'd0,   1'b0, 8'd0},
        '{OP_ADD,   8'd255, 1'b0, 8'd0},
        '{OP_ADD,   8'd255, 1'b0, 8'd0},
        '{OP_SPARE, 8'd255, 1'b0, 8'd0},    // must not count as a pixel
        '{OP_BUILD, 8'd0,   1'b0, 8'd0},
        '{OP_MAP,   8'd0,   1'b0, 8'd0},    // one third: rounding
        '{OP_MAP,   8'd1,   1'b0, 8'd0},
        '{OP_MAP,   8'd254, 1'b0, 8'd0},
        '{OP_MAP,   8'd255, 1'b1, 8'd255},  // full running sum saturates high
        '{OP_ADD,   8'd128, 1'b0, 8'd0},    // histogram was cleared by the build
        '{OP_BUILD, 8'd0,   1'b0, 8'd0},
        '{OP_MAP,   8'd127, 1'b1, 8'd0},
        '{OP_MAP,   8'd128, 1'b1, 8'd255},
        '{OP_MAP,   8'd255, 1'b1, 8'd255},
        '{OP_BUILD, 8'd0,   1'b0, 8'd0},    // second build on a cleared histogram
        '{OP_MAP,   8'd128, 1'b1, 8'd0},
        '{OP_MAP,   8'd0,   1'b1, 8'd0}
    };

    logic  aclk          = 1'b0;
    logic  aresetn       = 1'b0;
    logic  s_valid       = 1'b0;
    logic  s_ready;
    logic  [1:0] s_operation = OP_ADD;
    luma_t s_luma        = '0;
    logic  m_valid;
    logic  m_ready       = 1'b0;
    luma_t m_mapped_luma;

    // Side info that travels with the payload: a typed-in result for map rows.
    logic  drv_has_want  = 1'b0;
    luma_t drv_want      = '0;

    // Predictor state, a copy of the block's histogram, pixel total and map.
    count_t bin_tally [LEVELS];
    count_t pixel_count;
    luma_t  eq_map [LEVELS];

    luma_t  expected_mapped [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  n_adds = 0, n_adds_dropped = 0, n_builds = 0, n_empty_builds = 0;
    int  n_maps = 0, n_spare = 0, n_results = 0;
    int  tx_idle_pct = 0, rx_idle_pct = 0;
    int  rx_stall_left = 0;
    bit  steady_phase = 1'b0;

    luma_histogram_equalizer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_luma        (s_luma),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mapped_luma (m_mapped_luma)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_histogram();
        for (int i = 0; i < LEVELS; i++) begin
            bin_tally[i] = '0;
        end
        pixel_count = '0;
    endfunction

    // Count one sample unless the histogram is already full.
    function automatic void tally_pixel(luma_t y);
        if (pixel_count < MAX_PIXELS) begin
            bin_tally[y] = bin_tally[y] + 1'b1;
            pixel_count  = pixel_count + 1'b1;
        end else begin
            n_adds_dropped++;
        end
    endfunction

    // Walk the bins, map each level to round-half-up(255 * cum / total), then clear.
    function automatic void build_eq_map();
        count_t           running;
        logic [NUM_W-1:0] numer;
        logic [NUM_W-1:0] denom;
        logic [NUM_W-1:0] quo;
        running = '0;
        if (pixel_count == '0) begin
            n_empty_builds++;
        end
        for (int i = 0; i < LEVELS; i++) begin
            running = running + bin_tally[i];
            if (pixel_count == '0) begin
                eq_map[i] = '0;
            end else begin
                numer     = NUM_W'(510) * NUM_W'(running) + NUM_W'(pixel_count);
                denom     = NUM_W'(pixel_count) << 1;
                quo       = numer / denom;
                eq_map[i] = (quo > NUM_W'(255)) ? 8'd255 : quo[7:0];
            end
        end
        clear_histogram();
    endfunction

    initial begin
        clear_histogram();
        for (int i = 0; i < LEVELS; i++) begin
            eq_map[i] = '0;
        end
    end

    // ------------------------------------------------- predict, check, watchdog
    // Handle the input side first, so a result could never race its own prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                case (s_operation)
                    OP_ADD: begin
                        n_adds++;
                        tally_pixel(s_luma);
                    end
                    OP_BUILD: begin
                        n_builds++;
                        build_eq_map();
                    end
                    OP_MAP: begin
                        n_maps++;
                        expected_mapped.push_back(drv_has_want ? drv_want : eq_map[s_luma]);
                    end
                    default: begin
                        n_spare++;
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                n_results++;
                if (expected_mapped.size() == 0) begin
                    $error("mapped_luma: no result expected, actual %0d", m_mapped_luma);
                    mismatch_count++;
                end else if (m_mapped_luma !== expected_mapped[0]) begin
                    $error("mapped_luma: expected %0d, actual %0d",
                           expected_mapped[0], m_mapped_luma);
                    mismatch_count++;
                    void'(expected_mapped.pop_front());
                end else begin
                    void'(expected_mapped.pop_front());
                end
            end

            // Count cycles in which neither side moves an item.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without an item, %0d results pending",
                         quiet_cycles, expected_mapped.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------- result receiver
    // Stall in bursts at a rate set per phase; never in the tail.
    always begin
        @(negedge aclk);
        if (!aresetn || steady_phase) begin
            m_ready       = 1'b1;
            rx_stall_left = 0;
        end else if (rx_stall_left > 0) begin
            m_ready       = 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            m_ready       = 1'b0;
            rx_stall_left = $urandom_range(1, 18) - 1;
        end else begin
            m_ready       = 1'b1;
        end
    end

    // ------------------------------------------------------------------ sender

    // Present one item at a falling edge, hold it until accepted, return at the
    // next falling edge. An idle burst may come first, with valid dropped.
    task automatic drive_item(logic [1:0] op, luma_t y, logic has_want, luma_t want);
        int gap;
        if (!steady_phase && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap     = $urandom_range(1, 18);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_operation  = op;
        s_luma       = y;
        drv_has_want = has_want;
        drv_want     = want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every pending result has come back.
    task automatic wait_drained();
        s_valid = 1'b0;
        do begin
            @(negedge aclk);
        end while (expected_mapped.size() != 0);
    endtask

    initial begin
        int    random_sent;
        int    n_add_phase;
        int    n_map_phase;
        int    lo;
        int    hi;
        int    pick;
        luma_t y;

        random_sent = 0;

        // Hold reset for a few cycles, release on a falling edge.
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: moderate idling on both sides.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (int r = 0; r < N_DIRECTED; r++) begin
            drive_item(DIRECTED[r].op, DIRECTED[r].luma, DIRECTED[r].has_want,
                       DIRECTED[r].want);
        end
        wait_drained();

        // Random phases: a burst of adds over a luma window, a build, then maps.
        // Histogram full needs millions of adds and is left to the predictor.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= STEADY_FROM) begin
                steady_phase = 1'b1;
            end
            pick        = $urandom_range(0, 2);
            tx_idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 5 : 25);
            pick        = $urandom_range(0, 2);
            rx_idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 5 : 25);

            // Pick a window: narrow ones give steep curves, full ones gentle curves.
            lo = $urandom_range(0, 255);
            hi = $urandom_range(lo, 255);
            if ($urandom_range(0, 3) == 0) begin
                lo = 0;
                hi = 255;
            end

            // Mostly fresh histograms; sometimes none at all for an empty build.
            n_add_phase = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 160);
            for (int k = 0; k < n_add_phase; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    // Noise: spare code, does not count toward the item total.
                    drive_item(OP_SPARE, luma_t'($urandom_range(0, 255)), 1'b0, '0);
                end else if (pick < 7) begin
                    // Stray map against the previous table.
                    drive_item(OP_MAP, luma_t'($urandom_range(0, 255)), 1'b0, '0);
                    random_sent++;
                end else begin
                    y = ($urandom_range(0, 19) == 0) ? luma_t'(($urandom_range(0, 1) != 0)
                        ? 255 : 0) : luma_t'($urandom_range(lo, hi));
                    drive_item(OP_ADD, y, 1'b0, '0);
                    random_sent++;
                end
            end

            drive_item(OP_BUILD, '0, 1'b0, '0);
            random_sent++;
            if ($urandom_range(0, 9) == 0) begin
                // Back-to-back build: the second one sees a cleared histogram.
                drive_item(OP_BUILD, '0, 1'b0, '0);
                random_sent++;
            end

            // Read back the table, mostly around the window where it changes.
            n_map_phase = $urandom_range(16, 80);
            for (int k = 0; k < n_map_phase; k++) begin
                if ($urandom_range(0, 1) != 0) begin
                    y = luma_t'($urandom_range(lo, hi));
                end else begin
                    y = luma_t'($urandom_range(0, 255));
                end
                drive_item(OP_MAP, y, 1'b0, '0);
                random_sent++;
            end

            if (!steady_phase && $urandom_range(0, 3) == 0) begin
                wait_drained();
            end
        end

        // Let the last results come back, then give a late build time to finish.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d adds (%0d dropped), %0d builds (%0d empty), %0d maps",
                 n_adds, n_adds_dropped, n_builds, n_empty_builds, n_maps);
        $display("%0d spare-code items ignored, %0d results checked, %0d mismatches",
                 n_spare, n_results, mismatch_count);
        if (mismatch_count == 0 && expected_mapped.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
